>>> hdl/pfse_pkg.sv
`timescale 1ns / 1ps

package pfse_pkg;

	localparam int DEFAULT_POINTER_WIDTH = 64;
	localparam int DEFAULT_COUNT_WIDTH   = 32;
	localparam int QUEUE_DEPTH           = 2;

	localparam int FMT_W   = 8;
	localparam int ARG_W   = 64;
	localparam int CHARS_W = 32;
	localparam int WORD_W  = 32;

	// Octal of a 32-bit word is the longest non-pointer digit string.
	localparam int MIN_DIGITS = 11;

	// floor(n / 10) == (n * DEC_RECIP) >> DEC_SHIFT for any 32-bit n
	localparam logic [WORD_W-1:0] DEC_RECIP = 32'hCCCC_CCCD;
	localparam int                DEC_SHIFT = 35;

	localparam logic [7:0] CHAR_PCT   = 8'h25;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_X     = 8'h78;
	localparam logic [7:0] CHAR_UA    = 8'h41;
	localparam logic [7:0] CHAR_LA    = 8'h61;

	localparam logic [7:0] CONV_D = 8'h64;
	localparam logic [7:0] CONV_U = 8'h75;
	localparam logic [7:0] CONV_O = 8'h6F;
	localparam logic [7:0] CONV_X = 8'h78;
	localparam logic [7:0] CONV_P = 8'h70;
	localparam logic [7:0] CONV_C = 8'h63;

	typedef enum logic [1:0] {
		RDX_DEC = 2'd0,
		RDX_OCT = 2'd1,
		RDX_HEX = 2'd2
	} radix_t;

	// One request from front to back: up to two literal characters, then an
	// optional number. End requests carry the done flag; bare ones emit no char.
	typedef struct packed {
		logic [1:0] pre_len;
		logic [7:0] pre_a;
		logic [7:0] pre_b;
		logic       num_en;
		radix_t     radix;
		logic       lower;
		logic       is_end;
		logic       bare;
	} pfse_cmd_t;

	function automatic logic [7:0] digit_ascii(input logic [3:0] d, input logic lower);
		logic [7:0] base;
		base = lower ? CHAR_LA : CHAR_UA;
		if (d < 4'd10) begin
			return CHAR_ZERO + {4'b0, d};
		end
		return base + {4'b0, d} - 8'd10;
	endfunction

endpackage

>>> hdl/pfse_front.sv
`timescale 1ns / 1ps

module pfse_front import pfse_pkg::*; #(
	parameter int POINTER_WIDTH = DEFAULT_POINTER_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [FMT_W-1:0]         fmt_char,
	input  logic [ARG_W-1:0]         arg_value,
	input  logic                     end_of_format,
	input  logic                     q_full,
	output logic                     push,
	output pfse_cmd_t                push_cmd,
	output logic [POINTER_WIDTH-1:0] push_val
);

	logic              pending_q;
	logic              accept;
	logic              emits;
	logic [WORD_W-1:0] word;
	logic [WORD_W-1:0] mag;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign word     = arg_value[WORD_W-1:0];
	assign mag      = ~word + 1'b1;

	always_comb begin
		push_cmd = '0;
		push_val = '0;
		emits    = 1'b1;
		if (end_of_format) begin
			push_cmd.is_end = 1'b1;
			if (pending_q) begin
				push_cmd.pre_len = 2'd1;
				push_cmd.pre_a   = CHAR_PCT;
			end else begin
				push_cmd.bare = 1'b1;
			end
		end else if (pending_q) begin
			unique case (fmt_char)
				CONV_D: begin
					push_cmd.num_en = 1'b1;
					push_cmd.radix  = RDX_DEC;
					if (word[WORD_W-1]) begin
						push_cmd.pre_len = 2'd1;
						push_cmd.pre_a   = CHAR_MINUS;
						push_val         = POINTER_WIDTH'(mag);
					end else begin
						push_val = POINTER_WIDTH'(word);
					end
				end
				CONV_U: begin
					push_cmd.num_en = 1'b1;
					push_cmd.radix  = RDX_DEC;
					push_val        = POINTER_WIDTH'(word);
				end
				CONV_O: begin
					push_cmd.num_en = 1'b1;
					push_cmd.radix  = RDX_OCT;
					push_val        = POINTER_WIDTH'(word);
				end
				CONV_X: begin
					push_cmd.num_en = 1'b1;
					push_cmd.radix  = RDX_HEX;
					push_val        = POINTER_WIDTH'(word);
				end
				CONV_P: begin
					push_cmd.pre_len = 2'd2;
					push_cmd.pre_a   = CHAR_ZERO;
					push_cmd.pre_b   = CHAR_X;
					push_cmd.num_en  = 1'b1;
					push_cmd.radix   = RDX_HEX;
					push_cmd.lower   = 1'b1;
					push_val         = arg_value[POINTER_WIDTH-1:0];
				end
				CONV_C: begin
					push_cmd.pre_len = 2'd1;
					push_cmd.pre_a   = arg_value[7:0];
				end
				CHAR_PCT: begin
					push_cmd.pre_len = 2'd1;
					push_cmd.pre_a   = CHAR_PCT;
				end
				default: begin
					// unknown conversion: echo the percent and the byte
					push_cmd.pre_len = 2'd2;
					push_cmd.pre_a   = CHAR_PCT;
					push_cmd.pre_b   = fmt_char;
				end
			endcase
		end else if (fmt_char == CHAR_PCT) begin
			emits = 1'b0;
		end else begin
			push_cmd.pre_len = 2'd1;
			push_cmd.pre_a   = fmt_char;
		end
	end

	assign push = accept && emits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
		end else if (accept) begin
			pending_q <= !end_of_format && !pending_q && (fmt_char == CHAR_PCT);
		end
	end

endmodule

>>> hdl/pfse_queue.sv
`timescale 1ns / 1ps

module pfse_queue import pfse_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             rvalid,
	output logic [WIDTH-1:0] rdata
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign rvalid  = (count_q != '0);
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && rvalid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/pfse_back.sv
`timescale 1ns / 1ps

module pfse_back import pfse_pkg::*; #(
	parameter int POINTER_WIDTH = DEFAULT_POINTER_WIDTH,
	parameter int COUNT_WIDTH   = DEFAULT_COUNT_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	input  pfse_cmd_t                q_cmd,
	input  logic [POINTER_WIDTH-1:0] q_val,
	output logic                     pop,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [7:0]               out_char,
	output logic                     char_valid,
	output logic                     run_last,
	output logic [CHARS_W-1:0]       chars_written,
	output logic                     format_done
);

	localparam int HEX_DIGITS = (POINTER_WIDTH + 3) / 4;
	localparam int DIG_DEPTH  = (HEX_DIGITS > MIN_DIGITS) ? HEX_DIGITS : MIN_DIGITS;
	localparam int IDX_W      = $clog2(DIG_DEPTH);
	localparam int CNT_W      = $clog2(DIG_DEPTH + 1);
	localparam int QUOT_W     = 2 * WORD_W - DEC_SHIFT;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PRE  = 6'b000010,
		ST_CONV = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_EMIT = 6'b010000,
		ST_BARE = 6'b100000
	} state_t;

	state_t                   state_q;
	pfse_cmd_t                cmd_q;
	logic [POINTER_WIDTH-1:0] val_q;
	logic                     pre_idx_q;
	logic [CNT_W-1:0]         dig_cnt_q;
	logic [3:0]               dig_q [DIG_DEPTH];
	logic [2*WORD_W-1:0]      prod_q;
	logic [COUNT_WIDTH-1:0]   total_q;

	logic                     out_valid_q;
	logic [7:0]               out_char_q;
	logic                     char_valid_q;
	logic                     run_last_q;
	logic [CHARS_W-1:0]       chars_q;
	logic                     done_q;

	logic                     slot_free;
	logic                     pre_last;
	logic [IDX_W-1:0]         rd_idx;
	logic [IDX_W-1:0]         wr_idx;
	logic                     emit;
	logic [7:0]               emit_char;
	logic                     emit_cv;
	logic                     emit_last;
	logic                     emit_done;
	logic [COUNT_WIDTH-1:0]   total_inc;
	logic [COUNT_WIDTH-1:0]   count_next;
	logic [2*WORD_W-1:0]      prod_d;
	logic [QUOT_W-1:0]        quot;
	logic [WORD_W-1:0]        quot_x10;
	logic [WORD_W-1:0]        rem;
	logic [POINTER_WIDTH-1:0] shifted;
	logic [3:0]               low_digit;

	assign slot_free = !out_valid_q || out_ready;
	assign pre_last  = (pre_idx_q == (cmd_q.pre_len == 2'd2));
	assign rd_idx    = IDX_W'(dig_cnt_q - 1'b1);
	assign wr_idx    = dig_cnt_q[IDX_W-1:0];
	assign pop       = (state_q == ST_IDLE) && q_valid;

	// Decimal digit: multiply by the reciprocal, then take back the quotient.
	assign prod_d   = val_q[WORD_W-1:0] * DEC_RECIP;
	assign quot     = prod_q[2*WORD_W-1:DEC_SHIFT];
	assign quot_x10 = WORD_W'({quot, 3'b000}) + WORD_W'({quot, 1'b0});
	assign rem      = val_q[WORD_W-1:0] - quot_x10;

	assign shifted   = (cmd_q.radix == RDX_OCT) ? (val_q >> 3) : (val_q >> 4);
	assign low_digit = (cmd_q.radix == RDX_OCT) ? {1'b0, val_q[2:0]} : val_q[3:0];

	assign total_inc  = (total_q == '1) ? total_q : total_q + 1'b1;
	assign count_next = emit_cv ? total_inc : total_q;

	always_comb begin
		emit      = 1'b0;
		emit_char = '0;
		emit_cv   = 1'b1;
		emit_last = 1'b0;
		unique case (state_q)
			ST_PRE: begin
				emit      = slot_free;
				emit_char = pre_idx_q ? cmd_q.pre_b : cmd_q.pre_a;
				emit_last = pre_last && !cmd_q.num_en;
			end
			ST_EMIT: begin
				emit      = slot_free;
				emit_char = digit_ascii(dig_q[rd_idx], cmd_q.lower);
				emit_last = (dig_cnt_q == CNT_W'(1));
			end
			ST_BARE: begin
				emit      = slot_free;
				emit_cv   = 1'b0;
				emit_last = 1'b1;
			end
			default: begin
			end
		endcase
		emit_done = cmd_q.is_end && emit_last;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			cmd_q <= q_cmd;
			val_q <= q_val;
		end else if (state_q == ST_CONV && cmd_q.radix != RDX_DEC) begin
			val_q <= shifted;
		end else if (state_q == ST_DIV) begin
			val_q <= POINTER_WIDTH'(quot);
		end
		if (state_q == ST_CONV) begin
			prod_q <= prod_d;
			if (cmd_q.radix != RDX_DEC) begin
				dig_q[wr_idx] <= low_digit;
			end
		end else if (state_q == ST_DIV) begin
			dig_q[wr_idx] <= rem[3:0];
		end
		if (emit) begin
			out_char_q   <= emit_char;
			char_valid_q <= emit_cv;
			run_last_q   <= emit_last;
			chars_q      <= CHARS_W'(count_next);
			done_q       <= emit_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pre_idx_q   <= 1'b0;
			dig_cnt_q   <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				total_q     <= emit_done ? '0 : count_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					pre_idx_q <= 1'b0;
					dig_cnt_q <= '0;
					if (q_valid) begin
						if (q_cmd.bare) begin
							state_q <= ST_BARE;
						end else if (q_cmd.pre_len != 2'd0) begin
							state_q <= ST_PRE;
						end else begin
							state_q <= ST_CONV;
						end
					end
				end
				ST_PRE: begin
					if (emit) begin
						if (pre_last) begin
							state_q <= cmd_q.num_en ? ST_CONV : ST_IDLE;
						end else begin
							pre_idx_q <= 1'b1;
						end
					end
				end
				ST_CONV: begin
					if (cmd_q.radix == RDX_DEC) begin
						state_q <= ST_DIV;
					end else begin
						dig_cnt_q <= dig_cnt_q + 1'b1;
						if (shifted == '0) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_DIV: begin
					dig_cnt_q <= dig_cnt_q + 1'b1;
					state_q   <= (quot == '0) ? ST_EMIT : ST_CONV;
				end
				ST_EMIT: begin
					if (emit) begin
						dig_cnt_q <= dig_cnt_q - 1'b1;
						if (emit_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_BARE: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign out_char      = out_char_q;
	assign char_valid    = char_valid_q;
	assign run_last      = run_last_q;
	assign chars_written = chars_q;
	assign format_done   = done_q;

`ifndef SYNTH
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_q |-> run_last_q)
		else $error("format_done without run_last");

	a_bare_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !char_valid_q |-> done_q)
		else $error("bare result outside an end request");

	a_count_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit && emit_done |=> total_q == '0)
		else $error("character count not cleared after end");

	a_digits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (dig_cnt_q != '0) && (dig_cnt_q <= CNT_W'(DIG_DEPTH)))
		else $error("digit buffer count out of range");
`endif

endmodule

>>> hdl/printf_format_stream_engine_top.sv
`timescale 1ns / 1ps

// Streaming printf-style formatter. Feed one format byte per request on the
// input channel together with the argument that byte may consume; ASCII
// characters come out one per request on the output channel. Plain bytes are
// copied through. A '%' emits nothing by itself and waits for the next byte,
// which picks the conversion: d (signed 32-bit decimal), u (unsigned decimal),
// o (octal), x (uppercase hex), p ("0x" plus lowercase hex of POINTER_WIDTH
// bits), c (low byte of the argument), % (a literal '%'); anything else comes
// out as '%' followed by that byte. A request with end_of_format set closes the
// string: a dangling '%' is flushed, otherwise a single bare result with
// char_valid low is sent, and either way the last result carries format_done
// and the final count. run_last marks the last result of each input request,
// and chars_written is the running count, saturating at 2^COUNT_WIDTH-1, reset
// to zero after each end request. Timing: the front end takes one request per
// cycle while its two-entry queue has room; the back end fetches a request
// only when idle, emits its literal characters, and for numbers peels off
// hex or octal digits by shifting or decimal digits by a reciprocal multiply
// and a remainder step, then emits the digits most significant first. Each
// emit waits while the output register is full and not taken. The decimal
// digit loop runs through the 32x32 multiplier, and every character leaves
// through the single output register.
module printf_format_stream_engine_top import pfse_pkg::*; #(
	parameter int POINTER_WIDTH = DEFAULT_POINTER_WIDTH,
	parameter int COUNT_WIDTH   = DEFAULT_COUNT_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [FMT_W-1:0]   fmt_char,
	input  logic [ARG_W-1:0]   arg_value,
	input  logic               end_of_format,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_char,
	output logic               char_valid,
	output logic               run_last,
	output logic [CHARS_W-1:0] chars_written,
	output logic               format_done
);

	localparam int CMD_W = $bits(pfse_cmd_t);
	localparam int QW    = CMD_W + POINTER_WIDTH;

	logic                     q_full;
	logic                     push;
	pfse_cmd_t                push_cmd;
	logic [POINTER_WIDTH-1:0] push_val;
	logic                     q_valid;
	logic [QW-1:0]            q_rdata;
	logic                     pop;

	// Front end: tracks the pending percent and turns each byte into a request.
	pfse_front #(
		.POINTER_WIDTH(POINTER_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.fmt_char     (fmt_char),
		.arg_value    (arg_value),
		.end_of_format(end_of_format),
		.q_full       (q_full),
		.push         (push),
		.push_cmd     (push_cmd),
		.push_val     (push_val)
	);

	// Short queue decouples byte intake from character generation.
	pfse_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata ({push_val, push_cmd}),
		.full  (q_full),
		.pop   (pop),
		.rvalid(q_valid),
		.rdata (q_rdata)
	);

	// Back end: emits literals, converts numbers and keeps the running count.
	pfse_back #(
		.POINTER_WIDTH(POINTER_WIDTH),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_cmd        (pfse_cmd_t'(q_rdata[CMD_W-1:0])),
		.q_val        (q_rdata[QW-1:CMD_W]),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_char     (out_char),
		.char_valid   (char_valid),
		.run_last     (run_last),
		.chars_written(chars_written),
		.format_done  (format_done)
	);

endmodule

>>> tb/sv/tb_printf_format_stream_engine_top.sv
`timescale 1ns / 1ps

// Stimulus and self-checking environment for the streaming printf formatter.
// Each accepted request runs through a local model of the formatter that queues
// the characters it should produce. A monitor pops that queue on every output
// handshake and compares all fields.
module tb_printf_format_stream_engine_top;
	import pfse_pkg::*;

	localparam int          PTR_W     = DEFAULT_POINTER_WIDTH;
	localparam logic [31:0] COUNT_CAP = 32'((64'd1 << DEFAULT_COUNT_WIDTH) - 64'd1);
	localparam int          IDLE_PCT  = 37;
	localparam int          LONG_HOLD = 300;

	// One output character, as the block should present it.
	typedef struct packed {
		logic [7:0]         code;
		logic               has_char;
		logic               is_last;
		logic [CHARS_W-1:0] total;
		logic               is_done;
	} emitted_char_t;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               in_valid      = 1'b0;
	logic               in_ready;
	logic [FMT_W-1:0]   fmt_char      = '0;
	logic [ARG_W-1:0]   arg_value     = '0;
	logic               end_of_format = 1'b0;
	logic               out_valid;
	logic               out_ready     = 1'b0;
	logic [7:0]         out_char;
	logic               char_valid;
	logic               run_last;
	logic [CHARS_W-1:0] chars_written;
	logic               format_done;

	// Local copy of the formatter state.
	bit                 fmt_pct_pending;
	logic [CHARS_W-1:0] fmt_char_count;

	emitted_char_t expected_chars[$];
	emitted_char_t run_chars[$];

	bit steady           = 1'b0;
	int hold_off_request = 0;
	int hold_left        = 0;
	int mismatch_count   = 0;
	int requests_sent    = 0;
	int chars_checked    = 0;
	int strings_closed   = 0;
	int conversions_sent = 0;

	printf_format_stream_engine_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.fmt_char      (fmt_char),
		.arg_value     (arg_value),
		.end_of_format (end_of_format),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_char      (out_char),
		.char_valid    (char_valid),
		.run_last      (run_last),
		.chars_written (chars_written),
		.format_done   (format_done)
	);

	always #4 clk = ~clk;

	// Append one character to the current run; the count saturates.
	function automatic void push_char(input logic [7:0] c);
		emitted_char_t e;
		if (fmt_char_count != COUNT_CAP) begin
			fmt_char_count++;
		end
		e.code     = c;
		e.has_char = 1'b1;
		e.is_last  = 1'b0;
		e.total    = fmt_char_count;
		e.is_done  = 1'b0;
		run_chars.push_back(e);
	endfunction

	// Emit the digits of v, most significant first; zero gives a single '0'.
	function automatic void push_digits(input logic [63:0] v, input radix_t rdx,
					    input bit lower_case);
		logic [7:0] digs[$];
		logic [3:0] d;
		logic [7:0] alpha;
		alpha = lower_case ? CHAR_LA : CHAR_UA;
		if (v == '0) begin
			digs.push_front(CHAR_ZERO);
		end
		while (v != '0) begin
			case (rdx)
				RDX_DEC: begin
					d = 4'(v % 64'd10);
					v = v / 64'd10;
				end
				RDX_OCT: begin
					d = {1'b0, v[2:0]};
					v = v >> 3;
				end
				default: begin
					d = v[3:0];
					v = v >> 4;
				end
			endcase
			digs.push_front((d < 4'd10) ? CHAR_ZERO + 8'(d) : alpha + 8'(d) - 8'd10);
		end
		foreach (digs[i]) begin
			push_char(digs[i]);
		end
	endfunction

	// Work out the characters one accepted request produces and queue them.
	function automatic void predict_request(input logic [7:0] ch, input logic [63:0] arg,
						input logic eof);
		logic [31:0]   w;
		emitted_char_t e;
		run_chars.delete();
		w = arg[31:0];
		if (eof) begin
			if (fmt_pct_pending) begin
				push_char(CHAR_PCT);
			end
			// Nothing to flush: a bare completion result carries the count.
			if (run_chars.size() == 0) begin
				e          = '0;
				e.total    = fmt_char_count;
				run_chars.push_back(e);
			end
			e         = run_chars.pop_back();
			e.is_done = 1'b1;
			run_chars.push_back(e);
			fmt_pct_pending = 1'b0;
			fmt_char_count  = '0;
		end else if (fmt_pct_pending) begin
			fmt_pct_pending = 1'b0;
			case (ch)
				CONV_D: begin
					if (w[31]) begin
						push_char(CHAR_MINUS);
						w = ~w + 32'd1;
					end
					push_digits(64'(w), RDX_DEC, 1'b0);
				end
				CONV_U: push_digits(64'(w), RDX_DEC, 1'b0);
				CONV_O: push_digits(64'(w), RDX_OCT, 1'b0);
				CONV_X: push_digits(64'(w), RDX_HEX, 1'b0);
				CONV_P: begin
					push_char(CHAR_ZERO);
					push_char(CHAR_X);
					push_digits(arg & (~64'd0 >> (64 - PTR_W)), RDX_HEX, 1'b1);
				end
				CONV_C:   push_char(arg[7:0]);
				CHAR_PCT: push_char(CHAR_PCT);
				default: begin
					push_char(CHAR_PCT);
					push_char(ch);
				end
			endcase
		end else if (ch == CHAR_PCT) begin
			fmt_pct_pending = 1'b1;
		end else begin
			push_char(ch);
		end
		if (run_chars.size() != 0) begin
			e         = run_chars.pop_back();
			e.is_last = 1'b1;
			run_chars.push_back(e);
		end
		foreach (run_chars[i]) begin
			expected_chars.push_back(run_chars[i]);
		end
	endfunction

	// Offer one request, with random idle cycles ahead of it unless in a steady
	// stretch, and hold it until the block takes it. Valid stays high on return.
	task automatic send_request(input logic [7:0] ch, input logic [63:0] arg,
				    input logic eof);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		fmt_char      <= ch;
		arg_value     <= arg;
		end_of_format <= eof;
		do begin
			@(posedge clk);
		end while (!in_ready);
		predict_request(ch, arg, eof);
		requests_sent++;
		if (eof) begin
			strings_closed++;
		end
	endtask

	// A '%' request followed by its conversion byte, both carrying the argument.
	task automatic send_conversion(input logic [7:0] conv, input logic [63:0] arg);
		send_request(CHAR_PCT, arg, 1'b0);
		send_request(conv, arg, 1'b0);
		conversions_sent++;
	endtask

	// Drop valid and hold until every queued character has come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (expected_chars.size() != 0);
	endtask

	// Bias arguments toward zero, all ones, small numbers and the sign boundary.
	function automatic logic [63:0] pick_arg();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			2:       return {$urandom, 32'($urandom_range(9))};
			3:       return {$urandom, 32'h8000_0000};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic test_directed();
		send_request(8'h00, '0, 1'b0);
		send_request(8'hFF, '1, 1'b0);
		send_conversion(CONV_D, 64'hFFFF_FFFF_8000_0000);
		send_conversion(CONV_D, 64'h0000_0000_7FFF_FFFF);
		send_conversion(CONV_U, 64'h0000_0000_FFFF_FFFF);
		send_conversion(CONV_O, 64'h1234_5678_FFFF_FFFF);
		send_conversion(CONV_X, 64'h0000_0000_FEDC_BA98);
		send_conversion(CONV_P, '1);
		send_conversion(CONV_C, 64'hAAAA_AAAA_AAAA_AA80);
		send_conversion(CHAR_PCT, 64'h5555_5555_5555_5555);
		// unknown conversions: string and a zero byte
		send_conversion("s", '0);
		send_conversion(8'h00, '1);
		// dangling percent flushed by the end mark, then a bare end
		send_request(CHAR_PCT, '0, 1'b0);
		send_request(8'hA5, '1, 1'b1);
		send_request(8'h5A, '0, 1'b1);
	endtask

	// Stall the output for a long stretch while pointers keep arriving, so the
	// front queue fills and in_ready drops.
	task automatic test_backpressure();
		hold_off_request = LONG_HOLD;
		repeat (8) begin
			send_conversion(CONV_P, {$urandom | 32'h8000_0000, $urandom});
		end
		send_request(8'h00, '0, 1'b1);
	endtask

	// Let the block run dry in the middle of a format string, then finish it.
	task automatic test_drain_pause();
		send_conversion(CONV_D, 64'h0000_0000_8000_0001);
		send_request(CHAR_PCT, '0, 1'b0);
		wait_drained();
		send_request(CONV_X, 64'h0000_0000_0000_ABCD, 1'b0);
		send_request("!", '0, 1'b1);
	endtask

	// Mostly well-formed format strings with random content; some noise.
	task automatic test_random(input int n_items);
		int         sent;
		int         pick;
		logic [7:0] conv;
		sent   = 0;
		steady = 1'b1;
		while (sent < n_items) begin
			// Drop the steady stretch after the first part.
			if (sent >= 40) begin
				steady = 1'b0;
			end
			pick = $urandom_range(99);
			if (pick < 30) begin
				send_request(8'($urandom), pick_arg(), 1'b0);
				sent += 1;
			end else if (pick < 80) begin
				case ($urandom_range(7))
					0:       conv = CONV_D;
					1:       conv = CONV_U;
					2:       conv = CONV_O;
					3:       conv = CONV_X;
					4:       conv = CONV_P;
					5:       conv = CONV_C;
					6:       conv = CHAR_PCT;
					default: conv = 8'($urandom);
				endcase
				send_conversion(conv, pick_arg());
				sent += 2;
			end else if (pick < 92) begin
				send_request(8'($urandom), pick_arg(), 1'b1);
				sent += 1;
			end else begin
				send_request(CHAR_PCT, pick_arg(), 1'b0);
				send_request(8'($urandom), pick_arg(), 1'b1);
				sent += 2;
			end
		end
		steady = 1'b0;
	endtask

	// Output side: random stalls, plus one long hold-off counted here.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_off_request != 0) begin
			out_ready        <= 1'b0;
			hold_left        <= hold_off_request - 1;
			hold_off_request = 0;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	task automatic flag_mismatch(input string what, input logic [63:0] want,
				     input logic [63:0] got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
		end
	endtask

	// Compare each output request against the oldest queued character.
	always @(posedge clk) begin
		emitted_char_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_chars.size() == 0) begin
				flag_mismatch("unexpected output", '0, {out_char, chars_written});
			end else begin
				e = expected_chars.pop_front();
				chars_checked++;
				if (out_char !== e.code)
					flag_mismatch("out_char", e.code, out_char);
				if (char_valid !== e.has_char)
					flag_mismatch("char_valid", e.has_char, char_valid);
				if (run_last !== e.is_last)
					flag_mismatch("run_last", e.is_last, run_last);
				if (chars_written !== e.total)
					flag_mismatch("chars_written", e.total, chars_written);
				if (format_done !== e.is_done)
					flag_mismatch("format_done", e.is_done, format_done);
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_drain_pause();
		test_random(170);
		// Drain, then leave room for any stray output past the last one.
		wait_drained();
		repeat (60) @(posedge clk);
		if (expected_chars.size() != 0) begin
			flag_mismatch("missing output", expected_chars.size(), 0);
		end
		$display("run covered %0d requests (%0d conversions, %0d format strings closed)",
			 requests_sent, conversions_sent, strings_closed);
		$display("checked %0d output characters under random stalls and one long hold-off",
			 chars_checked);
		if (mismatch_count == 0) begin
			$display("tb_printf_format_stream_engine_top passed");
		end else begin
			$display("tb_printf_format_stream_engine_top failed");
		end
		$finish;
	end

	// Hard stop well past the slowest legal run.
	initial begin
		#2_000_000;
		$display("timeout with %0d characters still expected", expected_chars.size());
		$display("tb_printf_format_stream_engine_top failed");
		$finish;
	end

endmodule

>>> sim.f
hdl/pfse_pkg.sv
hdl/pfse_front.sv
hdl/pfse_queue.sv
hdl/pfse_back.sv
hdl/printf_format_stream_engine_top.sv
tb/sv/tb_printf_format_stream_engine_top.sv
